// ===== src/wlmc_pkg.sv =====
// Shared types and constants for the watch list match-and-clear block.
package wlmc_pkg;

  localparam int SLOTS_DEFAULT = 32;
  localparam int FN_W = 52;
  localparam int IDX_W = 5;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_ARM   = 1'b0,
    OP_CHECK = 1'b1
  } op_kind_t;

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    op_kind_t          kind;
    logic              fn_zero;
    logic [FN_W-1:0]   frame_number;
  } op_word_t;

endpackage

// ===== src/watch_list_match_and_clear.sv =====
// Path: a word passes the front register, the queue and the back-end result register
// before its result is valid, and waits longer while the result side stalls.
// Throughput: one word per cycle while the result side does not stall; the back end
// compares all slots at once and its single result register sets the pace.
// Reset: synchronous; clears every table slot to empty and drops all words in flight,
// so words are accepted from the first cycle after reset.
module watch_list_match_and_clear #(
  parameter int SLOTS = wlmc_pkg::SLOTS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic                       kind,
  input  logic [wlmc_pkg::FN_W-1:0]  frame_number,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic                       success,
  output logic [wlmc_pkg::IDX_W-1:0] slot_index,
  output logic                       table_full
);

  logic               fr_valid;
  logic               fr_ready;
  wlmc_pkg::op_word_t fr_word;
  logic               bk_valid;
  logic               bk_ready;
  wlmc_pkg::op_word_t bk_word;

  wlmc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .frame_number (frame_number),
    .op_valid     (fr_valid),
    .op_ready     (fr_ready),
    .op_word      (fr_word)
  );

  wlmc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_word  (fr_word),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_word  (bk_word)
  );

  wlmc_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (bk_valid),
    .op_ready     (bk_ready),
    .op_word      (bk_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .success      (success),
    .slot_index   (slot_index),
    .table_full   (table_full)
  );

endmodule

// ===== src/wlmc_front.sv =====
// Front end: accepts input words, classifies them and hands them to the queue.
module wlmc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic                     kind,
  input  logic [wlmc_pkg::FN_W-1:0] frame_number,
  output logic                     op_valid,
  input  logic                     op_ready,
  output wlmc_pkg::op_word_t       op_word
);

  logic               held;
  wlmc_pkg::op_word_t word;

  // No word is taken while reset is high, since reset empties the holding register.
  assign item_ready = !rst && (!held || op_ready);
  assign op_valid   = held;
  assign op_word    = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_ready) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      word.kind         <= kind ? wlmc_pkg::OP_CHECK : wlmc_pkg::OP_ARM;
      word.fn_zero      <= (frame_number == '0);
      word.frame_number <= frame_number;
    end
  end

endmodule

// ===== src/wlmc_queue.sv =====
// Short queue between the front end and the back end.
module wlmc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  wlmc_pkg::op_word_t wr_word,
  output logic               rd_valid,
  input  logic               rd_ready,
  output wlmc_pkg::op_word_t rd_word
);

  localparam int DEPTH = wlmc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wlmc_pkg::op_word_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_word  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/wlmc_back.sv =====
// Back end: holds the watch table, arms or matches and clears, registers the result.
module wlmc_back #(
  parameter int SLOTS = wlmc_pkg::SLOTS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       op_valid,
  output logic                       op_ready,
  input  wlmc_pkg::op_word_t         op_word,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic                       success,
  output logic [wlmc_pkg::IDX_W-1:0] slot_index,
  output logic                       table_full
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [wlmc_pkg::FN_W-1:0] watch_table [SLOTS];
  logic [SLOTS-1:0]          empty_vec;
  logic [SLOTS-1:0]          match_vec;
  logic [SLOTS-1:0]          pick_vec;
  logic                      found;
  logic [SLOT_W-1:0]         found_idx;
  logic [SLOT_W+wlmc_pkg::IDX_W-1:0] idx_ext;
  logic                      is_arm;
  logic                      take;

  assign is_arm   = (op_word.kind == wlmc_pkg::OP_ARM);
  assign op_ready = !result_valid || result_ready;
  assign take     = op_valid && op_ready;

  // Every slot is compared at once; the lowest set bit wins.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      empty_vec[i] = (watch_table[i] == '0);
      match_vec[i] = !empty_vec[i] && !op_word.fn_zero &&
                     (watch_table[i] == op_word.frame_number);
    end
  end

  assign pick_vec = is_arm ? empty_vec : match_vec;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pick_vec[i]) begin
        found     = 1'b1;
        found_idx = SLOT_W'(i);
      end
    end
  end

  assign idx_ext = {{wlmc_pkg::IDX_W{1'b0}}, found_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        watch_table[i] <= '0;
      end
    end else if (take && found) begin
      watch_table[found_idx] <= is_arm ? op_word.frame_number : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (op_ready) begin
      result_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      success    <= found;
      slot_index <= found ? idx_ext[wlmc_pkg::IDX_W-1:0] : '0;
      table_full <= is_arm && !found;
    end
  end

endmodule
